FILE: hw/rtl/dfpa_pkg.sv
`default_nettype none

package dfpa_pkg;

  // largest operand and result scale
  localparam int unsigned MAX_SCALE = 18;

  // operation codes
  localparam logic [2:0] MODE_ADD     = 3'd0;
  localparam logic [2:0] MODE_SUB     = 3'd1;
  localparam logic [2:0] MODE_MUL     = 3'd2;
  localparam logic [2:0] MODE_DIV     = 3'd3;
  localparam logic [2:0] MODE_RESCALE = 3'd4;

  // rounding codes
  localparam logic [2:0] RND_EXACT = 3'd0;
  localparam logic [2:0] RND_TRUNC = 3'd1;
  localparam logic [2:0] RND_AWAY  = 3'd2;
  localparam logic [2:0] RND_FLOOR = 3'd3;
  localparam logic [2:0] RND_CEIL  = 3'd4;
  localparam logic [2:0] RND_EVEN  = 3'd5;

  // status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_OVF   = 3'd1;
  localparam logic [2:0] ST_LOSS  = 3'd2;
  localparam logic [2:0] ST_SCALE = 3'd3;
  localparam logic [2:0] ST_DIV0  = 3'd4;
  localparam logic [2:0] ST_RND   = 3'd5;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_MUL,
    S_SCALE,
    S_COMBINE,
    S_DIV,
    S_ROUND,
    S_STRIP,
    S_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic mul_step;
    logic scale_step;
    logic combine;
    logic div_step;
    logic round;
    logic strip_step;
    logic out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic err;
    logic is_addsub;
    logic is_mul;
    logic mul_last;
    logic scale_done;
    logic div_last;
    logic strip_done;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dfpa_ctrl.sv
`default_nettype none

module dfpa_ctrl
  import dfpa_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_PREP;
      end
      S_PREP: begin
        if (stat_i.err) state_d = S_DONE;
        else if (stat_i.is_mul) state_d = S_MUL;
        else state_d = S_SCALE;
      end
      S_MUL: begin
        if (stat_i.mul_last) state_d = S_SCALE;
      end
      S_SCALE: begin
        if (stat_i.scale_done) state_d = stat_i.is_addsub ? S_COMBINE : S_DIV;
      end
      S_COMBINE: state_d = S_STRIP;
      S_DIV: begin
        if (stat_i.div_last) state_d = S_ROUND;
      end
      S_ROUND: state_d = stat_i.is_addsub ? S_DONE : S_STRIP;
      S_STRIP: begin
        if (stat_i.strip_done) state_d = stat_i.is_addsub ? S_ROUND : S_DONE;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE:    cmd_o.load       = in_valid_i;
      S_PREP:    cmd_o            = '0;
      S_MUL:     cmd_o.mul_step   = 1'b1;
      S_SCALE:   cmd_o.scale_step = !stat_i.scale_done;
      S_COMBINE: cmd_o.combine    = 1'b1;
      S_DIV:     cmd_o.div_step   = 1'b1;
      S_ROUND:   cmd_o.round      = 1'b1;
      S_STRIP:   cmd_o.strip_step = !stat_i.strip_done;
      S_DONE:    cmd_o.out_load   = out_free;
      default:   cmd_o            = '0;
    endcase
  end

  // output beat valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_err_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> !stat_i.err)
    else $error("divider running on a rejected item");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_q)
    else $error("loaded result not presented");

  a_accept_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_valid_i) |=> (state_q == S_PREP))
    else $error("accepted beat not taken into work");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/dfpa_dp.sv
`default_nettype none

module dfpa_dp
  import dfpa_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire dp_cmd_t            cmd_i,
  output dp_stat_t                stat_o,
  input  wire logic        [2:0]  mode_i,
  input  wire logic signed [63:0] a_coef_i,
  input  wire logic        [4:0]  a_scale_i,
  input  wire logic signed [63:0] b_coef_i,
  input  wire logic        [4:0]  b_scale_i,
  input  wire logic        [4:0]  target_scale_i,
  input  wire logic        [2:0]  rounding_i,
  output logic signed      [63:0] result_coef_o,
  output logic             [4:0]  result_scale_o,
  output logic             [2:0]  status_o
);

  // reciprocal of ten, scaled by 2^23, for the digit stripper
  localparam logic [19:0] RECIP10 = 20'd838861;
  localparam logic [63:0] LIM_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] LIM_NEG = 64'h8000_0000_0000_0000;

  // operation registers
  logic [2:0]   mode_q, rnd_q, status_q, status_d;
  logic         an_q, bn_q, neg_q, neg_d;
  logic [4:0]   scale_q, scale_d;
  logic [191:0] n_q, n_d;
  logic [127:0] d_q, d_d, rem_q, rem_d, w_q, w_d, qt_q, qt_d;
  logic [63:0]  bm_q, bm_d;
  logic [5:0]   kn_q, kn_d, kd_q, kd_d, mcnt_q, mcnt_d;
  logic [7:0]   dcnt_q, dcnt_d;
  logic [2:0]   cc_q, cc_d;
  logic [3:0]   rr_q, rr_d;
  logic         stop_q, stop_d;
  logic signed [63:0] res_coef_q;
  logic [4:0]   res_scale_q;
  logic [2:0]   res_status_q;

  // operand decode
  logic [63:0]  am, bm;
  logic         an, bn;
  logic [4:0]   s_max;
  logic [6:0]   div_e, mul_sh, e_neg;
  logic [2:0]   ld_status;
  logic [191:0] ld_n;
  logic [127:0] ld_d;
  logic [5:0]   ld_kn, ld_kd;
  logic [4:0]   ld_scale;
  logic         ld_neg;

  assign an = a_coef_i[63];
  assign bn = b_coef_i[63];
  assign am = an ? (~a_coef_i + 64'd1) : a_coef_i;
  assign bm = bn ? (~b_coef_i + 64'd1) : b_coef_i;
  assign s_max  = (a_scale_i > b_scale_i) ? a_scale_i : b_scale_i;
  assign div_e  = 7'(target_scale_i) + 7'(b_scale_i) - 7'(a_scale_i);
  assign mul_sh = 7'(target_scale_i) - 7'(a_scale_i) - 7'(b_scale_i);

  // up-front checks, in priority order
  always_comb begin
    ld_status = ST_OK;
    if (mode_i > MODE_RESCALE) ld_status = ST_RND;
    else if (a_scale_i > 5'(MAX_SCALE) || (mode_i < MODE_RESCALE && b_scale_i > 5'(MAX_SCALE)))
      ld_status = ST_SCALE;
    else if (mode_i >= MODE_MUL) begin
      if (rounding_i > RND_EVEN) ld_status = ST_RND;
      else if (target_scale_i > 5'(MAX_SCALE)) ld_status = ST_SCALE;
      else if (mode_i == MODE_DIV && bm == 64'd0) ld_status = ST_DIV0;
    end
  end

  // initial dividend, divisor and power-of-ten counts per operation
  always_comb begin
    ld_n     = {128'd0, am};
    ld_d     = 128'd1;
    ld_kn    = '0;
    ld_kd    = '0;
    ld_scale = target_scale_i;
    ld_neg   = an ^ bn;
    e_neg    = 7'd0;
    unique case (mode_i)
      MODE_ADD, MODE_SUB: begin
        ld_d     = {64'd0, bm};
        ld_kn    = 6'(s_max - a_scale_i);
        ld_kd    = 6'(s_max - b_scale_i);
        ld_scale = s_max;
        ld_neg   = an;
      end
      MODE_MUL: begin
        ld_n  = '0;
        ld_d  = {64'd0, am};
        e_neg = 7'd0 - mul_sh;
        if (mul_sh[6]) ld_kd = e_neg[5:0];
        else ld_kn = mul_sh[5:0];
      end
      MODE_DIV: begin
        ld_d  = {64'd0, bm};
        e_neg = 7'd0 - div_e;
        if (div_e[6]) ld_kd = e_neg[5:0];
        else ld_kn = div_e[5:0];
      end
      default: begin
        ld_neg = an;
        if (target_scale_i < a_scale_i) ld_kd = 6'(a_scale_i - target_scale_i);
        else ld_scale = a_scale_i;
      end
    endcase
  end

  // arithmetic helpers
  logic [128:0] div_sh, div_diff;
  logic         div_ge;
  logic [127:0] cx, cy;
  logic         cyn;
  logic [191:0] rt;
  logic [63:0]  lim;
  logic         big, f_zero, f_low, f_high, f_half, inc;
  logic [128:0] rem2, dz;
  logic [2:0]   rnd_status;
  logic [3:0]   rr_in, sr;
  logic [19:0]  sv;
  logic [39:0]  sp;
  logic [15:0]  sq;
  logic [127:0] qt_new;

  assign div_sh   = {rem_q, n_q[191]};
  assign div_ge   = div_sh >= {1'b0, d_q};
  assign div_diff = div_sh - {1'b0, d_q};

  assign cx  = n_q[127:0];
  assign cy  = d_q;
  assign cyn = (mode_q == MODE_SUB) ? !bn_q : bn_q;

  // rounding decision
  always_comb begin
    rt     = stat_o.is_addsub ? {64'd0, w_q} : n_q;
    lim    = neg_q ? LIM_NEG : LIM_POS;
    big    = (rt[191:64] != 128'd0) || (rt[63:0] > lim);
    rem2   = {rem_q, 1'b0};
    dz     = {1'b0, d_q};
    f_zero = stat_o.is_addsub || (rem_q == 128'd0);
    f_low  = !f_zero && (rem2 < dz);
    f_high = !f_zero && (rem2 > dz);
    f_half = !f_zero && !f_low && !f_high;
    unique case (rnd_q)
      RND_AWAY:  inc = 1'b1;
      RND_FLOOR: inc = neg_q;
      RND_CEIL:  inc = !neg_q;
      RND_EVEN:  inc = f_high || (f_half && rt[0]);
      default:   inc = 1'b0;
    endcase
    // nothing discarded, nothing to round
    if (f_zero) inc = 1'b0;
    priority if (big) rnd_status = ST_OVF;
    else if (f_zero) rnd_status = ST_OK;
    else if (rnd_q == RND_EXACT) rnd_status = ST_LOSS;
    else if (inc && rt[63:0] >= lim) rnd_status = ST_OVF;
    else rnd_status = ST_OK;
  end

  // one 16-bit chunk of a divide by ten
  always_comb begin
    rr_in  = (cc_q == 3'd7) ? 4'd0 : rr_q;
    sv     = {rr_in, w_q[{cc_q, 4'b0} +: 16]};
    sp     = sv * RECIP10;
    sq     = sp[38:23];
    sr     = 4'(sv - 20'(sq) * 20'd10);
    qt_new = qt_q;
    qt_new[{cc_q, 4'b0} +: 16] = sq;
  end

  // next-state of the datapath
  always_comb begin
    n_d      = n_q;
    d_d      = d_q;
    bm_d     = bm_q;
    rem_d    = rem_q;
    w_d      = w_q;
    qt_d     = qt_q;
    kn_d     = kn_q;
    kd_d     = kd_q;
    mcnt_d   = mcnt_q;
    dcnt_d   = dcnt_q;
    cc_d     = cc_q;
    rr_d     = rr_q;
    stop_d   = stop_q;
    scale_d  = scale_q;
    neg_d    = neg_q;
    status_d = status_q;
    if (cmd_i.load) begin
      n_d      = ld_n;
      d_d      = ld_d;
      bm_d     = bm;
      rem_d    = '0;
      kn_d     = ld_kn;
      kd_d     = ld_kd;
      mcnt_d   = '1;
      dcnt_d   = 8'd191;
      cc_d     = 3'd7;
      stop_d   = 1'b0;
      scale_d  = ld_scale;
      neg_d    = ld_neg;
      status_d = ld_status;
    end
    if (cmd_i.mul_step) begin
      if (bm_q[0]) n_d = n_q + {64'd0, d_q};
      d_d    = (mcnt_q == 6'd0) ? 128'd1 : (d_q << 1);
      bm_d   = bm_q >> 1;
      mcnt_d = mcnt_q - 6'd1;
    end
    if (cmd_i.scale_step) begin
      if (kn_q != 6'd0) begin
        n_d  = (n_q << 3) + (n_q << 1);
        kn_d = kn_q - 6'd1;
      end
      if (kd_q != 6'd0) begin
        d_d  = (d_q << 3) + (d_q << 1);
        kd_d = kd_q - 6'd1;
      end
    end
    if (cmd_i.combine) begin
      priority if (an_q == cyn) begin
        w_d   = cx + cy;
        neg_d = an_q;
      end else if (cx >= cy) begin
        w_d   = cx - cy;
        neg_d = an_q;
      end else begin
        w_d   = cy - cx;
        neg_d = cyn;
      end
    end
    if (cmd_i.div_step) begin
      rem_d  = div_ge ? div_diff[127:0] : div_sh[127:0];
      n_d    = {n_q[190:0], div_ge};
      dcnt_d = dcnt_q - 8'd1;
    end
    if (cmd_i.round) begin
      status_d = rnd_status;
      w_d      = {64'd0, rt[63:0] + 64'(inc)};
    end
    if (cmd_i.strip_step) begin
      qt_d = qt_new;
      rr_d = sr;
      cc_d = cc_q - 3'd1;
      if (cc_q == 3'd0) begin
        if (sr == 4'd0) begin
          w_d     = qt_new;
          scale_d = scale_q - 5'd1;
        end else begin
          stop_d = 1'b1;
        end
      end
    end
  end

  // status to the controller
  always_comb begin
    stat_o.err        = (status_q != ST_OK);
    stat_o.is_addsub  = (mode_q == MODE_ADD) || (mode_q == MODE_SUB);
    stat_o.is_mul     = (mode_q == MODE_MUL);
    stat_o.mul_last   = (mcnt_q == 6'd0);
    stat_o.scale_done = (kn_q == 6'd0) && (kd_q == 6'd0);
    stat_o.div_last   = (dcnt_q == 8'd0);
    stat_o.strip_done = (cc_q == 3'd7) && (stop_q || scale_q == 5'd0 || w_q == 128'd0);
  end

  // control counters and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kn_q     <= '0;
      kd_q     <= '0;
      mcnt_q   <= '0;
      dcnt_q   <= '0;
      cc_q     <= 3'd7;
      stop_q   <= 1'b0;
      status_q <= ST_OK;
    end else begin
      kn_q     <= kn_d;
      kd_q     <= kd_d;
      mcnt_q   <= mcnt_d;
      dcnt_q   <= dcnt_d;
      cc_q     <= cc_d;
      stop_q   <= stop_d;
      status_q <= status_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      rnd_q  <= rounding_i;
      an_q   <= an;
      bn_q   <= bn;
    end
    n_q     <= n_d;
    d_q     <= d_d;
    bm_q    <= bm_d;
    rem_q   <= rem_d;
    w_q     <= w_d;
    qt_q    <= qt_d;
    rr_q    <= rr_d;
    scale_q <= scale_d;
    neg_q   <= neg_d;
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      res_status_q <= status_q;
      if (status_q != ST_OK || w_q == 128'd0) begin
        res_coef_q  <= '0;
        res_scale_q <= '0;
      end else begin
        res_coef_q  <= neg_q ? (64'd0 - w_q[63:0]) : w_q[63:0];
        res_scale_q <= scale_q;
      end
    end
  end

  assign result_coef_o  = res_coef_q;
  assign result_scale_o = res_scale_q;
  assign status_o       = res_status_q;

endmodule

`default_nettype wire

FILE: hw/rtl/decimal_fixed_point_alu.sv
// Flow: a rejected item goes straight to the output; add/subtract scale, combine, strip
//   trailing zeros and round; multiply first runs the shift-add multiplier, and then
//   multiply, divide and rescale scale, run the bit-serial restoring divider, round, strip.
// Throughput: one item at a time; the next beat is taken once the result is registered.
// Reset (rst_ni, asynchronous, active low) empties the output and idles the sequencer.
`default_nettype none

module decimal_fixed_point_alu
  import dfpa_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic        [2:0]  mode_i,
  input  wire logic signed [63:0] a_coef_i,
  input  wire logic        [4:0]  a_scale_i,
  input  wire logic signed [63:0] b_coef_i,
  input  wire logic        [4:0]  b_scale_i,
  input  wire logic        [4:0]  target_scale_i,
  input  wire logic        [2:0]  rounding_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed      [63:0] result_coef_o,
  output logic             [4:0]  result_scale_o,
  output logic             [2:0]  status_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  dfpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // arithmetic
  dfpa_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .mode_i         (mode_i),
    .a_coef_i       (a_coef_i),
    .a_scale_i      (a_scale_i),
    .b_coef_i       (b_coef_i),
    .b_scale_i      (b_scale_i),
    .target_scale_i (target_scale_i),
    .rounding_i     (rounding_i),
    .result_coef_o  (result_coef_o),
    .result_scale_o (result_scale_o),
    .status_o       (status_o)
  );

endmodule

`default_nettype wire
